### design/ars_pkg.sv
// Shared types, constants and the letter ROM of the Arabic contextual shaper.
`timescale 1ns / 1ps

package ars_pkg;

    localparam int CP_W          = 21;
    localparam int FORM_W        = 16;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;
    localparam int ROM_SIZE      = 35;
    localparam int ROM_IDX_W     = 6;
    localparam int MARK_DEPTH_DEF = 4;

    localparam logic [ROM_IDX_W-1:0] ROM_LAST = ROM_IDX_W'(ROM_SIZE - 1);

    localparam logic [CP_W-1:0] TATWEEL_CP    = 21'h000640;
    localparam logic [CP_W-1:0] HARAKAT_LO    = 21'h00064B;
    localparam logic [CP_W-1:0] HARAKAT_HI    = 21'h00065F;
    localparam logic [CP_W-1:0] SIGNS_LO      = 21'h000610;
    localparam logic [CP_W-1:0] SIGNS_HI      = 21'h00061A;
    localparam logic [CP_W-1:0] COMBINING_LO  = 21'h000300;
    localparam logic [CP_W-1:0] COMBINING_HI  = 21'h00036F;

    typedef enum logic [1:0] {
        CLS_NONE        = 2'd0,
        CLS_RIGHT       = 2'd1,
        CLS_DUAL        = 2'd2,
        CLS_TRANSPARENT = 2'd3
    } join_cls_t;

    typedef struct packed {
        logic [FORM_W-1:0] base;
        join_cls_t         cls;
        logic [FORM_W-1:0] iso;
        logic [FORM_W-1:0] fin;
        logic [FORM_W-1:0] ini;
        logic [FORM_W-1:0] med;
    } letter_t;

    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [ROM_IDX_W-1:0] index;
    } scan_res_t;

    typedef struct packed {
        logic [CP_W-1:0] shaped;
        logic            changed;
        logic            ovf;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRE,
        ST_LETTER,
        ST_MARKS,
        ST_BODY,
        ST_POST,
        ST_DONE
    } state_t;

    function automatic letter_t rom_entry(input logic [ROM_IDX_W-1:0] idx);
        letter_t e;
        unique case (idx)
            6'd0:  e = '{16'h0622, CLS_RIGHT, 16'hFE81, 16'hFE82, 16'h0000, 16'h0000};
            6'd1:  e = '{16'h0623, CLS_RIGHT, 16'hFE83, 16'hFE84, 16'h0000, 16'h0000};
            6'd2:  e = '{16'h0624, CLS_RIGHT, 16'hFE85, 16'hFE86, 16'h0000, 16'h0000};
            6'd3:  e = '{16'h0625, CLS_RIGHT, 16'hFE87, 16'hFE88, 16'h0000, 16'h0000};
            6'd4:  e = '{16'h0627, CLS_RIGHT, 16'hFE8D, 16'hFE8E, 16'h0000, 16'h0000};
            6'd5:  e = '{16'h0629, CLS_RIGHT, 16'hFE93, 16'hFE94, 16'h0000, 16'h0000};
            6'd6:  e = '{16'h062F, CLS_RIGHT, 16'hFEA9, 16'hFEAA, 16'h0000, 16'h0000};
            6'd7:  e = '{16'h0630, CLS_RIGHT, 16'hFEAB, 16'hFEAC, 16'h0000, 16'h0000};
            6'd8:  e = '{16'h0631, CLS_RIGHT, 16'hFEAD, 16'hFEAE, 16'h0000, 16'h0000};
            6'd9:  e = '{16'h0632, CLS_RIGHT, 16'hFEAF, 16'hFEB0, 16'h0000, 16'h0000};
            6'd10: e = '{16'h0648, CLS_RIGHT, 16'hFEED, 16'hFEEE, 16'h0000, 16'h0000};
            6'd11: e = '{16'h0649, CLS_RIGHT, 16'hFEEF, 16'hFEF0, 16'h0000, 16'h0000};
            6'd12: e = '{16'h0626, CLS_DUAL, 16'hFE89, 16'hFE8A, 16'hFE8B, 16'hFE8C};
            6'd13: e = '{16'h0628, CLS_DUAL, 16'hFE8F, 16'hFE90, 16'hFE91, 16'hFE92};
            6'd14: e = '{16'h062A, CLS_DUAL, 16'hFE95, 16'hFE96, 16'hFE97, 16'hFE98};
            6'd15: e = '{16'h062B, CLS_DUAL, 16'hFE99, 16'hFE9A, 16'hFE9B, 16'hFE9C};
            6'd16: e = '{16'h062C, CLS_DUAL, 16'hFE9D, 16'hFE9E, 16'hFE9F, 16'hFEA0};
            6'd17: e = '{16'h062D, CLS_DUAL, 16'hFEA1, 16'hFEA2, 16'hFEA3, 16'hFEA4};
            6'd18: e = '{16'h062E, CLS_DUAL, 16'hFEA5, 16'hFEA6, 16'hFEA7, 16'hFEA8};
            6'd19: e = '{16'h0633, CLS_DUAL, 16'hFEB1, 16'hFEB2, 16'hFEB3, 16'hFEB4};
            6'd20: e = '{16'h0634, CLS_DUAL, 16'hFEB5, 16'hFEB6, 16'hFEB7, 16'hFEB8};
            6'd21: e = '{16'h0635, CLS_DUAL, 16'hFEB9, 16'hFEBA, 16'hFEBB, 16'hFEBC};
            6'd22: e = '{16'h0636, CLS_DUAL, 16'hFEBD, 16'hFEBE, 16'hFEBF, 16'hFEC0};
            6'd23: e = '{16'h0637, CLS_DUAL, 16'hFEC1, 16'hFEC2, 16'hFEC3, 16'hFEC4};
            6'd24: e = '{16'h0638, CLS_DUAL, 16'hFEC5, 16'hFEC6, 16'hFEC7, 16'hFEC8};
            6'd25: e = '{16'h0639, CLS_DUAL, 16'hFEC9, 16'hFECA, 16'hFECB, 16'hFECC};
            6'd26: e = '{16'h063A, CLS_DUAL, 16'hFECD, 16'hFECE, 16'hFECF, 16'hFED0};
            6'd27: e = '{16'h0641, CLS_DUAL, 16'hFED1, 16'hFED2, 16'hFED3, 16'hFED4};
            6'd28: e = '{16'h0642, CLS_DUAL, 16'hFED5, 16'hFED6, 16'hFED7, 16'hFED8};
            6'd29: e = '{16'h0643, CLS_DUAL, 16'hFED9, 16'hFEDA, 16'hFEDB, 16'hFEDC};
            6'd30: e = '{16'h0644, CLS_DUAL, 16'hFEDD, 16'hFEDE, 16'hFEDF, 16'hFEE0};
            6'd31: e = '{16'h0645, CLS_DUAL, 16'hFEE1, 16'hFEE2, 16'hFEE3, 16'hFEE4};
            6'd32: e = '{16'h0646, CLS_DUAL, 16'hFEE5, 16'hFEE6, 16'hFEE7, 16'hFEE8};
            6'd33: e = '{16'h0647, CLS_DUAL, 16'hFEE9, 16'hFEEA, 16'hFEEB, 16'hFEEC};
            6'd34: e = '{16'h064A, CLS_DUAL, 16'hFEF1, 16'hFEF2, 16'hFEF3, 16'hFEF4};
            default: e = '{16'h0000, CLS_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        endcase
        return e;
    endfunction

endpackage

### design/ars_letter_scan.sv
// Letter ROM search: one shared comparator walks the ROM one entry per cycle.
`timescale 1ns / 1ps

module ars_letter_scan
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ars_pkg::CP_W-1:0] code_point,
    output ars_pkg::scan_res_t       res
);
    import ars_pkg::*;

    logic [ROM_IDX_W-1:0] idx_reg, idx_next;
    logic                 busy_reg, busy_next;
    scan_res_t            res_reg, res_next;
    letter_t              cur;
    logic                 hit;

    always_comb
    begin
        cur = rom_entry(idx_reg);
        hit = (code_point == {{(CP_W - FORM_W){1'b0}}, cur.base});
    end

    always_comb
    begin
        idx_next      = idx_reg;
        busy_next     = busy_reg;
        res_next      = res_reg;
        res_next.done = 1'b0;
        if (start)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                res_next  = '{done: 1'b1, found: 1'b1, index: idx_reg};
                busy_next = 1'b0;
            end
            else if (idx_reg == ROM_LAST)
            begin
                res_next  = '{done: 1'b1, found: 1'b0, index: idx_reg};
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ROM_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### design/arabic_contextual_shaper.sv
// Top level of the Arabic contextual shaper: sequencer, held letter, mark store and output.
`timescale 1ns / 1ps

// The shaper takes one Unicode codepoint per transfer on the slave side, in logical
// order, with s_tlast marking the final codepoint of a text, and replaces each Arabic
// letter by its isolated, final, initial or medial presentation form. A dual-joining
// letter is held back, together with up to MARK_DEPTH combining marks that follow it,
// until its left neighbour or the end of text is known; the held items then leave in
// their original order. The block handles one codepoint at a time: after a transfer
// is taken, s_tready stays low while the letter ROM is searched by a single comparator,
// one entry per cycle, and stops at the matching entry or after the last one. The
// sequencer then takes up the search result, makes its decision, sends each flushed
// result of an earlier held letter and its marks, passes on or holds the codepoint
// itself (a step left out when a mark joins the store), and closes through its post
// and done states before s_tready rises again. Results pass through a one-deep
// pending stage and an output register, so stalls on the master side only hold the
// sequencer when both are full. m_tlast marks the last result caused by an input
// transfer, and the text_final bit marks the result of the final codepoint of a text.
// There is no clearing pass after reset; the mark store is only ever read below its
// fill count.
module arabic_contextual_shaper
#(
    parameter int MARK_DEPTH = ars_pkg::MARK_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [20:0] code_point, [23:21] zero
    input  logic [ars_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,   // end_of_text
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [20:0] shaped_point, [21] was_changed, [22] mark_overflow, [23] text_final
    output logic [ars_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast    // run_last
);
    import ars_pkg::*;

    // Mark store sizing: the count must hold the depth itself, the index does not.
    localparam int CNT_W = $clog2(MARK_DEPTH + 1);
    localparam int MI_W  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    state_t               state_reg, state_next;

    logic [CP_W-1:0]      cp_reg;
    logic                 eot_reg;

    join_cls_t            prior_reg, prior_next;
    logic                 held_valid_reg, held_valid_next;
    logic [ROM_IDX_W-1:0] held_idx_reg, held_idx_next;
    logic                 held_jr_reg, held_jr_next;

    logic [CP_W-1:0]      mark_store_reg [MARK_DEPTH];
    logic                 mark_we;
    logic [CNT_W-1:0]     mark_count_reg, mark_count_next;
    logic [MI_W-1:0]      mark_idx_reg, mark_idx_next;

    logic                 flush_jl_reg, flush_jl_next;
    logic                 flush_ovf_reg, flush_ovf_next;
    state_t               flush_ret_reg, flush_ret_next;

    logic                 pend_valid_reg, pend_valid_next;
    res_t                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg, out_res_next;
    logic                 out_final_reg, out_final_next;
    logic                 out_last_reg, out_last_next;

    scan_res_t            scan_res;
    logic                 accept;
    join_cls_t            cls;
    letter_t              hit_e;
    letter_t              held_e;
    logic [FORM_W-1:0]    flush_form;
    logic [FORM_W-1:0]    body_form;
    logic [CP_W-1:0]      mark_rd;
    logic                 out_free;
    logic                 can_prod;
    logic                 marks_room;
    logic                 marks_last;
    logic                 body_dual;
    logic                 prod;
    res_t                 prod_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    ars_letter_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .code_point (cp_reg),
        .res        (scan_res)
    );

    // Classification of the current codepoint, valid once the ROM search is done.
    always_comb
    begin
        hit_e = rom_entry(scan_res.index);
        if (cp_reg == TATWEEL_CP)
            cls = CLS_DUAL;
        else if ((cp_reg >= HARAKAT_LO && cp_reg <= HARAKAT_HI) ||
                 (cp_reg >= SIGNS_LO && cp_reg <= SIGNS_HI) ||
                 (cp_reg >= COMBINING_LO && cp_reg <= COMBINING_HI))
            cls = CLS_TRANSPARENT;
        else if (scan_res.found)
            cls = hit_e.cls;
        else
            cls = CLS_NONE;
    end

    // Presentation forms for the held letter being flushed and for a new letter.
    always_comb
    begin
        held_e = rom_entry(held_idx_reg);
        priority if (held_jr_reg && flush_jl_reg)
            flush_form = held_e.med;
        else if (held_jr_reg)
            flush_form = held_e.fin;
        else if (flush_jl_reg)
            flush_form = held_e.ini;
        else
            flush_form = held_e.iso;
        body_form = (prior_reg == CLS_DUAL) ? hit_e.fin : hit_e.iso;
    end

    assign body_dual  = scan_res.found && (hit_e.cls == CLS_DUAL);
    assign mark_rd    = mark_store_reg[mark_idx_reg];
    assign marks_room = (mark_count_reg < CNT_W'(MARK_DEPTH));
    assign marks_last = (CNT_W'(mark_idx_reg) == (mark_count_reg - CNT_W'(1)));

    // A new result may be produced when the pending stage is empty or can move on.
    assign out_free = !out_valid_reg || m_tready;
    assign can_prod = !pend_valid_reg || out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                    state_next = ST_PRE;
            end
            ST_PRE:
            begin
                // A held letter is flushed first unless the mark simply joins the store.
                if (held_valid_reg && !(cls == CLS_TRANSPARENT && marks_room))
                    state_next = ST_LETTER;
                else if (held_valid_reg)
                    state_next = ST_POST;
                else
                    state_next = ST_BODY;
            end
            ST_LETTER:
            begin
                if (can_prod)
                    state_next = (mark_count_reg == '0) ? flush_ret_reg : ST_MARKS;
            end
            ST_MARKS:
            begin
                if (can_prod && marks_last)
                    state_next = flush_ret_reg;
            end
            ST_BODY:
            begin
                if ((cls != CLS_TRANSPARENT && body_dual) || can_prod)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                state_next = (eot_reg && held_valid_reg) ? ST_LETTER : ST_DONE;
            end
            ST_DONE:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        prior_next      = prior_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        held_jr_next    = held_jr_reg;
        mark_we         = 1'b0;
        mark_count_next = mark_count_reg;
        mark_idx_next   = mark_idx_reg;
        flush_jl_next   = flush_jl_reg;
        flush_ovf_next  = flush_ovf_reg;
        flush_ret_next  = flush_ret_reg;
        prod            = 1'b0;
        prod_res        = '{shaped: cp_reg, changed: 1'b0, ovf: 1'b0};

        unique case (state_reg)
            ST_PRE:
            begin
                if (held_valid_reg)
                begin
                    if (cls == CLS_TRANSPARENT && marks_room)
                    begin
                        mark_we         = 1'b1;
                        mark_count_next = mark_count_reg + CNT_W'(1);
                    end
                    else if (cls == CLS_TRANSPARENT)
                    begin
                        // Store full: resolve the letter as if nothing joined on its left.
                        flush_jl_next  = 1'b0;
                        flush_ovf_next = 1'b1;
                        flush_ret_next = ST_BODY;
                    end
                    else
                    begin
                        flush_jl_next  = (cls == CLS_DUAL) || (cls == CLS_RIGHT);
                        flush_ovf_next = 1'b0;
                        flush_ret_next = ST_BODY;
                    end
                end
            end
            ST_LETTER:
            begin
                if (can_prod)
                begin
                    prod            = 1'b1;
                    prod_res.shaped = {{(CP_W - FORM_W){1'b0}}, flush_form};
                    prod_res.changed = (flush_form != held_e.base);
                    prod_res.ovf    = flush_ovf_reg;
                    held_valid_next = 1'b0;
                    mark_idx_next   = '0;
                end
            end
            ST_MARKS:
            begin
                if (can_prod)
                begin
                    prod            = 1'b1;
                    prod_res.shaped = mark_rd;
                    mark_idx_next   = mark_idx_reg + MI_W'(1);
                    if (marks_last)
                        mark_count_next = '0;
                end
            end
            ST_BODY:
            begin
                if (cls == CLS_TRANSPARENT)
                begin
                    prod = can_prod;
                end
                else if (body_dual)
                begin
                    held_valid_next = 1'b1;
                    held_idx_next   = scan_res.index;
                    held_jr_next    = (prior_reg == CLS_DUAL);
                    mark_count_next = '0;
                    prior_next      = cls;
                end
                else if (can_prod)
                begin
                    prod = 1'b1;
                    if (scan_res.found)
                    begin
                        prod_res.shaped  = {{(CP_W - FORM_W){1'b0}}, body_form};
                        prod_res.changed = ({{(CP_W - FORM_W){1'b0}}, body_form} != cp_reg);
                    end
                    prior_next = cls;
                end
            end
            ST_POST:
            begin
                if (eot_reg)
                begin
                    prior_next     = CLS_NONE;
                    flush_jl_next  = 1'b0;
                    flush_ovf_next = 1'b0;
                    flush_ret_next = ST_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Pending stage and output register. The newest result waits in the pending stage
    // until it is known whether another result of the same transfer follows it.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_res_next    = out_res_reg;
        out_final_next  = out_final_reg;
        out_last_next   = out_last_reg;

        if (prod)
        begin
            pend_valid_next = 1'b1;
            pend_next       = prod_res;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pend_reg;
                out_final_next = 1'b0;
                out_last_next  = 1'b0;
            end
        end
        else if (state_reg == ST_DONE && pend_valid_reg && out_free)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_res_next    = pend_reg;
            out_final_next  = eot_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prior_reg      <= CLS_NONE;
            held_valid_reg <= 1'b0;
            held_idx_reg   <= '0;
            held_jr_reg    <= 1'b0;
            mark_count_reg <= '0;
            mark_idx_reg   <= '0;
            flush_jl_reg   <= 1'b0;
            flush_ovf_reg  <= 1'b0;
            flush_ret_reg  <= ST_DONE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prior_reg      <= prior_next;
            held_valid_reg <= held_valid_next;
            held_idx_reg   <= held_idx_next;
            held_jr_reg    <= held_jr_next;
            mark_count_reg <= mark_count_next;
            mark_idx_reg   <= mark_idx_next;
            flush_jl_reg   <= flush_jl_next;
            flush_ovf_reg  <= flush_ovf_next;
            flush_ret_reg  <= flush_ret_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cp_reg  <= s_tdata[CP_W-1:0];
            eot_reg <= s_tlast;
        end
        if (mark_we)
            mark_store_reg[mark_count_reg[MI_W-1:0]] <= cp_reg;
        pend_reg      <= pend_next;
        out_res_reg   <= out_res_next;
        out_final_reg <= out_final_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_final_reg, out_res_reg.ovf, out_res_reg.changed, out_res_reg.shaped};
    assign m_tlast  = out_last_reg;

endmodule

### dv/tb.sv
// Self-checking testbench of the Arabic contextual shaper with its own shaping predictor.
`timescale 1ns / 1ps

// Codepoints go in one transfer at a time from a queue that the initial block fills.
// Every accepted codepoint is run through a behavioural shaper written here, and the
// results that it expects wait in a queue. Each result transfer that the block sends is
// compared field by field with the oldest waiting one. Both sides idle at random.
module tb;

    import ars_pkg::*;

    localparam int MARK_DEPTH   = MARK_DEPTH_DEF;
    localparam int LETTER_COUNT = 35;
    localparam int RIGHT_COUNT  = 12;        // the first twelve letters join on one side only
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;       // a letter search and its results fit well within this

    // Presentation forms follow the isolated form in a fixed order.
    localparam int FORM_ISO = 0;
    localparam int FORM_FIN = 1;
    localparam int FORM_INI = 2;
    localparam int FORM_MED = 3;

    localparam logic [CP_W-1:0] SPACE_CP = 21'h000020;
    localparam logic [CP_W-1:0] CP_TOP   = 21'h10FFFF;

    localparam logic [15:0] LETTER_BASE [LETTER_COUNT] = '{
        16'h0622, 16'h0623, 16'h0624, 16'h0625, 16'h0627, 16'h0629, 16'h062F,
        16'h0630, 16'h0631, 16'h0632, 16'h0648, 16'h0649, 16'h0626, 16'h0628,
        16'h062A, 16'h062B, 16'h062C, 16'h062D, 16'h062E, 16'h0633, 16'h0634,
        16'h0635, 16'h0636, 16'h0637, 16'h0638, 16'h0639, 16'h063A, 16'h0641,
        16'h0642, 16'h0643, 16'h0644, 16'h0645, 16'h0646, 16'h0647, 16'h064A
    };

    localparam logic [15:0] LETTER_ISO [LETTER_COUNT] = '{
        16'hFE81, 16'hFE83, 16'hFE85, 16'hFE87, 16'hFE8D, 16'hFE93, 16'hFEA9,
        16'hFEAB, 16'hFEAD, 16'hFEAF, 16'hFEED, 16'hFEEF, 16'hFE89, 16'hFE8F,
        16'hFE95, 16'hFE99, 16'hFE9D, 16'hFEA1, 16'hFEA5, 16'hFEB1, 16'hFEB5,
        16'hFEB9, 16'hFEBD, 16'hFEC1, 16'hFEC5, 16'hFEC9, 16'hFECD, 16'hFED1,
        16'hFED5, 16'hFED9, 16'hFEDD, 16'hFEE1, 16'hFEE5, 16'hFEE9, 16'hFEF1
    };

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            eot;
    } text_item_t;

    typedef struct {
        logic [CP_W-1:0] shaped;
        logic            changed;
        logic            ovf;
        logic            text_end;
        logic            step_last;
    } glyph_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    text_item_t text_queue [$];
    glyph_t     forms_due [$];
    glyph_t     step_out [$];
    text_item_t next_item;

    // Shaping state of the predictor.
    join_cls_t       prior_cls = CLS_NONE;
    bit              held = 1'b0;
    int              held_idx = 0;
    bit              held_jr = 1'b0;
    logic [CP_W-1:0] held_marks [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int tx_idle     = 0;
    int tx_calm     = 0;
    int rx_stall    = 0;
    int rx_calm     = 0;

    arabic_contextual_shaper #(.MARK_DEPTH(MARK_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int letter_index(input logic [CP_W-1:0] cp);
        for (int i = 0; i < LETTER_COUNT; i++)
        begin
            if (cp == CP_W'(LETTER_BASE[i]))
                return i;
        end
        return -1;
    endfunction

    function automatic join_cls_t class_of(input logic [CP_W-1:0] cp);
        int idx;
        if (cp == TATWEEL_CP)
            return CLS_DUAL;
        if ((cp >= HARAKAT_LO && cp <= HARAKAT_HI) || (cp >= SIGNS_LO && cp <= SIGNS_HI) ||
            (cp >= COMBINING_LO && cp <= COMBINING_HI))
            return CLS_TRANSPARENT;
        idx = letter_index(cp);
        if (idx < 0)
            return CLS_NONE;
        return (idx < RIGHT_COUNT) ? CLS_RIGHT : CLS_DUAL;
    endfunction

    function automatic void put_glyph(input logic [CP_W-1:0] orig, input logic [CP_W-1:0] shaped,
                                      input bit ovf);
        glyph_t g;
        g.shaped    = shaped;
        g.changed   = (shaped != orig);
        g.ovf       = ovf;
        g.text_end  = 1'b0;
        g.step_last = 1'b0;
        step_out.push_back(g);
    endfunction

    // Resolves the held letter from what is now known of its left side; its marks follow it.
    function automatic void release_held(input bit joins_left, input bit ovf);
        int form;
        if (held)
        begin
            if (held_jr && joins_left)
                form = FORM_MED;
            else if (held_jr)
                form = FORM_FIN;
            else if (joins_left)
                form = FORM_INI;
            else
                form = FORM_ISO;
            put_glyph(CP_W'(LETTER_BASE[held_idx]), CP_W'(LETTER_ISO[held_idx]) + CP_W'(form), ovf);
            foreach (held_marks[i])
                put_glyph(held_marks[i], held_marks[i], 1'b0);
        end
        held = 1'b0;
        held_marks.delete();
    endfunction

    function automatic void shape_codepoint(input logic [CP_W-1:0] cp, input logic eot);
        join_cls_t cls;
        int        idx;
        glyph_t    g;
        step_out.delete();
        cls = class_of(cp);
        if (cls == CLS_TRANSPARENT)
        begin
            if (!held)
                put_glyph(cp, cp, 1'b0);
            else if (held_marks.size() < MARK_DEPTH)
                held_marks.push_back(cp);
            else
            begin
                // Mark store full: the letter is resolved early, as if nothing joined after it.
                release_held(1'b0, 1'b1);
                put_glyph(cp, cp, 1'b0);
            end
        end
        else
        begin
            release_held(cls == CLS_DUAL || cls == CLS_RIGHT, 1'b0);
            idx = letter_index(cp);
            if (idx >= RIGHT_COUNT)
            begin
                held     = 1'b1;
                held_idx = idx;
                held_jr  = (prior_cls == CLS_DUAL);
            end
            else if (idx >= 0)
                put_glyph(cp, CP_W'(LETTER_ISO[idx]) +
                          CP_W'((prior_cls == CLS_DUAL) ? FORM_FIN : FORM_ISO), 1'b0);
            else
                put_glyph(cp, cp, 1'b0);
            prior_cls = cls;
        end
        if (eot)
        begin
            release_held(1'b0, 1'b0);
            prior_cls = CLS_NONE;
            if (step_out.size() != 0)
            begin
                g = step_out.pop_back();
                g.text_end = 1'b1;
                step_out.push_back(g);
            end
        end
        if (step_out.size() != 0)
        begin
            g = step_out.pop_back();
            g.step_last = 1'b1;
            step_out.push_back(g);
        end
        foreach (step_out[i])
            forms_due.push_back(step_out[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic check_glyph();
        glyph_t want;
        if (forms_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result transfer, data %h", m_tdata));
            return;
        end
        want = forms_due.pop_front();
        if (m_tdata[CP_W-1:0] !== want.shaped)
            report_mismatch($sformatf("shaped_point %h, expected %h", m_tdata[CP_W-1:0],
                                      want.shaped));
        if (m_tdata[CP_W] !== want.changed)
            report_mismatch($sformatf("was_changed %b, expected %b (point %h)", m_tdata[CP_W],
                                      want.changed, want.shaped));
        if (m_tdata[CP_W+1] !== want.ovf)
            report_mismatch($sformatf("mark_overflow %b, expected %b (point %h)",
                                      m_tdata[CP_W+1], want.ovf, want.shaped));
        if (m_tdata[CP_W+2] !== want.text_end)
            report_mismatch($sformatf("text_final %b, expected %b (point %h)", m_tdata[CP_W+2],
                                      want.text_end, want.shaped));
        if (m_tlast !== want.step_last)
            report_mismatch($sformatf("m_tlast %b, expected %b (point %h)", m_tlast,
                                      want.step_last, want.shaped));
    endtask

    // Input transfers feed the predictor before any result of the same edge is compared.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                shape_codepoint(s_tdata[CP_W-1:0], s_tlast);
            if (m_tvalid && m_tready)
                check_glyph();
        end
    end

    // ---------------------------------------------------------------- idling

    // Mostly no gap or a short one, now and then a long one, and calm stretches with none.
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (tx_idle > 0)
            begin
                s_tvalid <= 1'b0;
                tx_idle  <= tx_idle - 1;
            end
            else if (text_queue.size() != 0)
            begin
                next_item = text_queue.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= S_TDATA_W'(next_item.cp);
                s_tlast   <= next_item.eot;
                tx_idle   <= pick_idle(tx_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_stall <= pick_idle(rx_calm);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_text(input logic [CP_W-1:0] cp, input logic eot);
        text_item_t it;
        it.cp  = cp;
        it.eot = eot;
        text_queue.push_back(it);
    endfunction

    function automatic logic [CP_W-1:0] random_mark();
        case ($urandom_range(0, 2))
            0:       return CP_W'($urandom_range(HARAKAT_LO, HARAKAT_HI));
            1:       return CP_W'($urandom_range(SIGNS_LO, SIGNS_HI));
            default: return CP_W'($urandom_range(COMBINING_LO, COMBINING_HI));
        endcase
    endfunction

    // A text of letters with an occasional run of marks, some noise, and the end mark last.
    function automatic void add_random_text();
        int              len;
        int              r;
        logic [CP_W-1:0] cp;
        text_item_t      it;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                cp = CP_W'(LETTER_BASE[$urandom_range(RIGHT_COUNT, LETTER_COUNT - 1)]);
            else if (r < 62)
                cp = CP_W'(LETTER_BASE[$urandom_range(0, RIGHT_COUNT - 1)]);
            else if (r < 68)
                cp = TATWEEL_CP;
            else if (r < 76)
                cp = SPACE_CP;
            else if (r < 82)
                cp = random_mark();
            else if (r < 92)
                cp = CP_W'($urandom_range(0, CP_TOP));
            else
                cp = CP_W'($urandom_range(0, 21'h0006FF));
            queue_text(cp, 1'b0);
            if ($urandom_range(0, 3) == 0)
            begin
                // Runs longer than the mark store force an early resolution.
                repeat ($urandom_range(1, MARK_DEPTH + 2))
                    queue_text(random_mark(), 1'b0);
            end
        end
        it = text_queue.pop_back();
        it.eot = 1'b1;
        text_queue.push_back(it);
    endfunction

    initial
    begin
        int directed_count;

        // A lone non-letter, then a dual-joining letter with a full mark store and one mark more.
        queue_text(21'h000000, 1'b0);
        queue_text(21'h000628, 1'b0);
        queue_text(HARAKAT_LO, 1'b0);
        queue_text(HARAKAT_HI, 1'b0);
        queue_text(SIGNS_LO, 1'b0);
        queue_text(SIGNS_HI, 1'b0);
        queue_text(COMBINING_LO, 1'b0);
        // Nothing held: the mark passes straight through.
        queue_text(COMBINING_HI, 1'b0);
        // The early-resolved letter still joins the next one; tatweel then closes it medially.
        queue_text(21'h000644, 1'b0);
        queue_text(TATWEEL_CP, 1'b0);
        queue_text(21'h000627, 1'b0);
        queue_text(21'h000628, 1'b0);
        queue_text(21'h00064A, 1'b0);
        queue_text(21'h000622, 1'b0);
        queue_text(21'h00064A, 1'b1);
        queue_text(21'h000626, 1'b1);
        // Codepoints at and beyond the top of the range pass through unchanged.
        queue_text(CP_TOP, 1'b0);
        queue_text(21'h1FFFFF, 1'b0);
        queue_text(21'h000649, 1'b0);
        queue_text(21'h000628, 1'b0);
        queue_text(SPACE_CP, 1'b0);
        queue_text(21'h000648, 1'b1);
        // End of text on a mark flushes the held letter and its marks.
        queue_text(21'h000647, 1'b0);
        queue_text(21'h00064E, 1'b0);
        queue_text(21'h00064E, 1'b1);
        queue_text(21'h000651, 1'b1);
        directed_count = text_queue.size();

        while (text_queue.size() < directed_count + RANDOM_ITEMS)
            add_random_text();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (text_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (forms_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
